### rtl/psac_pkg.sv
// Package for the pixel store with alpha compositing.
// Holds the opcode codes, the pixel type, register indexes and the divide-by-255 rounding.
// Used by the interfaces, the blend unit and the top level.
`default_nettype none
package psac_pkg;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;

	localparam int OP_W      = 3;
	localparam int COORD_W   = 7;
	localparam int CHAN_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	localparam logic [CHAN_W-1:0]    CHAN_MAX    = 8'hFF;
	localparam logic [CFG_DAT_W-1:0] WIDTH_RST   = 8'd128;
	localparam logic [CFG_DAT_W-1:0] HEIGHT_RST  = 8'd128;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 3'd0,
		OP_COPY   = 3'd1,
		OP_OPQ_PT = 3'd2,
		OP_OPQ_FL = 3'd3,
		OP_BLEND  = 3'd4,
		OP_FILL   = 3'd5
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	// round(p / 255) for p up to 255 * 255; an exact half cannot occur
	function automatic logic [CHAN_W-1:0] div255_round(input logic [15:0] p);
		logic [16:0] t;
		logic [16:0] s;
		t = {1'b0, p} + 17'd128;
		s = t + (t >> 8);
		return s[15:8];
	endfunction

endpackage
`default_nettype wire

### rtl/psac_req_if.sv
// Request channel: one item carries an opcode, coordinates and a pixel.
// Depends on psac_pkg for field widths.
`default_nettype none
interface psac_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [psac_pkg::OP_W-1:0]             opcode;
	logic [psac_pkg::COORD_W-1:0]          x;
	logic [psac_pkg::COORD_W-1:0]          y;
	logic [psac_pkg::CHAN_W-1:0]           red;
	logic [psac_pkg::CHAN_W-1:0]           green;
	logic [psac_pkg::CHAN_W-1:0]           blue;
	logic [psac_pkg::CHAN_W-1:0]           alpha;

	modport source (output valid, opcode, x, y, red, green, blue, alpha, input ready);
	modport sink   (input valid, opcode, x, y, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

### rtl/psac_rsp_if.sv
// Response channel: one item carries the resulting pixel and the range flag.
// Depends on psac_pkg for field widths.
`default_nettype none
interface psac_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [psac_pkg::CHAN_W-1:0] out_red;
	logic [psac_pkg::CHAN_W-1:0] out_green;
	logic [psac_pkg::CHAN_W-1:0] out_blue;
	logic [psac_pkg::CHAN_W-1:0] out_alpha;
	logic                        range_error;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, range_error,
		input ready);
	modport sink   (input valid, out_red, out_green, out_blue, out_alpha, range_error,
		output ready);
endinterface
`default_nettype wire

### rtl/psac_blend.sv
// Blend unit: registered channel products, then rounding, sum and alpha saturation.
// Depends on psac_pkg for pixel_t and div255_round.
`default_nettype none
module psac_blend (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire psac_pkg::pixel_t old_px,
	input  wire psac_pkg::pixel_t new_px,
	output psac_pkg::pixel_t      blend_px
);
	import psac_pkg::*;

	logic [15:0]       old_r_s1, old_g_s1, old_b_s1;
	logic [15:0]       new_r_s1, new_g_s1, new_b_s1;
	logic [CHAN_W:0]   asum_s1;
	logic [CHAN_W-1:0] inv_a;

	assign inv_a = CHAN_MAX - new_px.alpha;

	always_ff @(posedge clk) begin
		if (en) begin
			old_r_s1 <= 16'(inv_a) * 16'(old_px.red);
			old_g_s1 <= 16'(inv_a) * 16'(old_px.green);
			old_b_s1 <= 16'(inv_a) * 16'(old_px.blue);
			new_r_s1 <= 16'(new_px.alpha) * 16'(new_px.red);
			new_g_s1 <= 16'(new_px.alpha) * 16'(new_px.green);
			new_b_s1 <= 16'(new_px.alpha) * 16'(new_px.blue);
			asum_s1  <= {1'b0, old_px.alpha} + {1'b0, new_px.alpha};
		end
	end

	always_comb begin
		blend_px.red   = div255_round(old_r_s1) + div255_round(new_r_s1);
		blend_px.green = div255_round(old_g_s1) + div255_round(new_g_s1);
		blend_px.blue  = div255_round(old_b_s1) + div255_round(new_b_s1);
		blend_px.alpha = asum_s1[CHAN_W] ? CHAN_MAX : asum_s1[CHAN_W-1:0];
	end
endmodule
`default_nettype wire

### rtl/pixel_store_with_alpha_compositing_core.sv
// Top level: RGBA pixel store in one synchronous memory with read, write and blend.
// Depends on psac_pkg, psac_req_if, psac_rsp_if and psac_blend.
//
//   channel | role   | carries
//   req     | sink   | opcode, x, y, red, green, blue, alpha
//   rsp     | source | out_red, out_green, out_blue, out_alpha, range_error
//   cfg     | write  | cfg_we, cfg_index, cfg_wdata (width, height)
//
// Read, write and conditional write go through a memory read, then decide and write back in ST_LOOK.
// Blend goes through the memory read, registered products in ST_LOOK, then sum and write back in ST_MUL.
// Fill writes every pixel of the width x height area in turn, row by row; an empty area writes nothing.
// Reset clears control and sets width and height to 128; store contents are undefined.
// A full result register stalls the final cycle of an item until rsp is taken.
`default_nettype none
module pixel_store_with_alpha_compositing_core #(
	parameter int MAX_WIDTH  = psac_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = psac_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [psac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [psac_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	psac_req_if.sink                              req,
	psac_rsp_if.source                            rsp
);
	import psac_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CWX   = $clog2(MAX_WIDTH + 1);
	localparam int CWY   = $clog2(MAX_HEIGHT + 1);
	localparam int CWM   = (CWX > CWY) ? CWX : CWY;
	localparam int CW    = (CWM > CFG_DAT_W) ? CWM : CFG_DAT_W;
	localparam int AXW   = AW + 8;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOOK = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_FILL = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CFG_DAT_W-1:0] width_q, height_q;
	logic [CW-1:0]      w_eff, h_eff;
	op_t                op_q;
	logic               op_bad_q;
	pixel_t             px_q, rd_q, blend_px, res_px;
	logic               err_q;
	logic [AW-1:0]      addr_q;
	logic [XW-1:0]      col_q;
	logic [YW-1:0]      row_q;
	logic [31:0]        mem [DEPTH];

	logic               accept, out_free, out_load, fill_empty, col_last, row_last;
	logic               mem_we, req_err, blend_en;
	logic [AW-1:0]      mem_waddr;
	pixel_t             mem_wdata;
	logic [AXW-1:0]     req_addr, fill_addr;

	assign w_eff = (CW'(width_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_q);
	assign h_eff = (CW'(height_q) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_q);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp.valid || rsp.ready;

	assign req_addr  = AXW'(req.y) * AXW'(MAX_WIDTH) + AXW'(req.x);
	assign fill_addr = AXW'(row_q) * AXW'(MAX_WIDTH) + AXW'(col_q);
	assign req_err   = (CW'(req.x) >= w_eff) || (CW'(req.y) >= h_eff);

	assign fill_empty = (w_eff == '0) || (h_eff == '0);
	assign col_last   = (CW'(col_q) + CW'(1)) == w_eff;
	assign row_last   = (CW'(row_q) + CW'(1)) == h_eff;
	assign blend_en   = (state_q == ST_LOOK);

	psac_blend u_blend (
		.clk      (clk),
		.en       (blend_en),
		.old_px   (rd_q),
		.new_px   (px_q),
		.blend_px (blend_px)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = px_q;
		out_load  = 1'b0;
		res_px    = '0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_LOOK: begin
				if (op_bad_q || err_q) begin
					res_px = '0;
				end else begin
					unique case (op_q)
						OP_READ:   res_px = rd_q;
						OP_COPY:   res_px = px_q;
						OP_OPQ_PT: res_px = (px_q.alpha != '0) ? px_q : rd_q;
						OP_OPQ_FL: res_px = (px_q.alpha == CHAN_MAX) ? px_q : rd_q;
						default:   res_px = rd_q;
					endcase
					mem_we = (op_q == OP_COPY) || (op_q == OP_OPQ_PT) || (op_q == OP_OPQ_FL);
				end
				mem_we    = mem_we && out_free;
				mem_wdata = res_px;
				out_load  = out_free && !(op_q == OP_BLEND && !op_bad_q && !err_q);
			end
			ST_MUL: begin
				res_px    = blend_px;
				mem_wdata = blend_px;
				mem_we    = out_free;
				out_load  = out_free;
			end
			ST_FILL: begin
				res_px    = px_q;
				mem_waddr = fill_addr[AW-1:0];
				mem_we    = !fill_empty;
				out_load  = out_free && (fill_empty || (col_last && row_last));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_q <= mem[req_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(req.opcode);
			op_bad_q <= (req.opcode > OP_FILL);
			px_q     <= {req.red, req.green, req.blue, req.alpha};
			err_q    <= req_err && (req.opcode <= OP_BLEND);
			addr_q   <= req_addr[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  width_q  <= cfg_wdata;
				CFG_HEIGHT: height_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					col_q <= '0;
					row_q <= '0;
					if (accept) begin
						state_q <= (req.opcode == OP_FILL) ? ST_FILL : ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (op_q == OP_BLEND && !op_bad_q && !err_q) begin
						state_q <= ST_MUL;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FILL: begin
					if (fill_empty || (col_last && row_last)) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else if (col_last) begin
						col_q <= '0;
						row_q <= row_q + YW'(1);
					end else begin
						col_q <= col_q + XW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (out_load) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.out_red     <= res_px.red;
			rsp.out_green   <= res_px.green;
			rsp.out_blue    <= res_px.blue;
			rsp.out_alpha   <= res_px.alpha;
			rsp.range_error <= err_q && (state_q == ST_LOOK);
		end
	end
endmodule
`default_nettype wire
